>>> sv/fema_pkg.sv
// Package with shared constants and types for the frame EMA filter.
package fema_pkg;

	localparam int PIXEL_BITS_DEF = 8;
	localparam int MAX_PIXELS_DEF = 524288;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int ALPHA_BITS = 16;
	localparam int SPIN_BITS  = 16;
	localparam int FRAME_BITS = 17;
	localparam int CFG_BITS   = 16;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd6554;
	localparam logic [SPIN_BITS-1:0]  SPIN_RESET  = 16'd1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA   = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPIN_UP = 1'b1;

	// Reciprocal sequencer states.
	typedef enum logic [1:0] {
		DS_IDLE,
		DS_WAIT,
		DS_RUN
	} div_state_t;

endpackage

>>> sv/frame_ema_with_spin_up.sv
// An accepted sample passes stages 1 to 4 and the output register; the frame store has
// one read and one write port. Throughput: one sample per cycle unless stalled.
// After each frame of the spin-up phase, a reciprocal of the frame number is formed
// bit by bit once the pipeline drains; a frame of four pixels or fewer stalls until
// the earlier update of the same entry is written.
// Reset (arst_n, asynchronous) clears the frame number to one, the pixel address to zero
// and loads the register defaults; the frame store is not cleared.
module frame_ema_with_spin_up
	import fema_pkg::*;
#(
	parameter int PIXEL_BITS = PIXEL_BITS_DEF,
	parameter int MAX_PIXELS = MAX_PIXELS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0] s_tdata, // sample, zero fill
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	output logic [((PIXEL_BITS+7)/8)*8-1:0] m_tdata, // filtered, zero fill
	output logic m_tlast,
	input  logic cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	localparam int W  = PIXEL_BITS + FRAC_BITS;
	localparam int RW = W + 1;
	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CW = $clog2(RW);
	localparam int DW = ((PIXEL_BITS + 7) / 8) * 8;
	localparam int QFW = W + FRAME_BITS;
	localparam logic [AW:0] LAST_ADDR = (AW+1)'(MAX_PIXELS - 1);

	// Configuration and frame state.
	logic [ALPHA_BITS-1:0] alpha_q;
	logic [SPIN_BITS-1:0]  spin_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [AW-1:0]         pix_q;
	logic [RW-1:0]         recip_q;

	// Frame store.
	logic [W-1:0] mem [MAX_PIXELS];

	// Reciprocal sequencer.
	div_state_t div_state_q, div_state_next;
	logic [CW-1:0]  cnt_q;
	logic [FRAME_BITS:0] rem_q;
	logic [RW-1:0]  quo_q;
	logic [FRAME_BITS:0] rem_shift;
	logic           rem_ge;
	logic           div_busy, div_run;

	// Pipeline.
	logic advance, hazard, acc, pipe_empty, div_now, frame_inc;
	logic [SPIN_BITS-1:0] eff_spin;

	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [AW-1:0]         addr_s1, addr_s2, addr_s3, addr_s4;
	logic                  last_s1, last_s2, last_s3, last_s4;
	logic                  div_s1, div_s2, div_s3, div_s4;
	logic [FRAME_BITS-1:0] f_s1, f_s2, f_s3, f_s4;
	logic [PIXEL_BITS-1:0] smp_s1;
	logic [W-1:0]          rd_s1;
	logic                  up_s2, up_s3, up_s4;
	logic [W-1:0]          avg_s2, avg_s3, avg_s4;
	logic [W-1:0]          mag_s2, mag_s3, mag_s4;
	logic [2*RW-1:0]       prod_s3;
	logic [W-1:0]          q_s4;
	logic [QFW-1:0]        qf_s4;

	logic [W-1:0]    x_s1, mag_s1, base_s1;
	logic            up_s1;
	logic [RW-1:0]   op_s2;
	logic [W-1:0]    q_s3;
	logic [QFW-1:0]  diff_s4;
	logic            corr_s4;
	logic [W-1:0]    step_s4, res_s4;
	logic [W:0]      rnd_s4;
	logic [PIXEL_BITS:0] sh_s4;
	logic [PIXEL_BITS-1:0] filt_s4;

	logic                  out_valid_q;
	logic [PIXEL_BITS-1:0] out_data_q;
	logic                  out_last_q;

	// Handshake and hazard detection.
	assign advance    = !out_valid_q || m_tready;
	assign pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4);
	assign hazard = (v_s1 && addr_s1 == pix_q) || (v_s2 && addr_s2 == pix_q) ||
		(v_s3 && addr_s3 == pix_q) || (v_s4 && addr_s4 == pix_q);
	assign s_tready = advance && !div_busy && !hazard;
	assign acc      = s_tvalid && s_tready;
	assign eff_spin = (spin_q == '0) ? SPIN_BITS'(1) : spin_q;
	assign div_now  = frame_q <= {1'b0, eff_spin};
	assign frame_inc = acc && s_tlast && div_now;

	// Configuration registers, frame number and pixel address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			spin_q  <= SPIN_RESET;
			frame_q <= FRAME_BITS'(1);
			pix_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ALPHA:   alpha_q <= cfg_data[ALPHA_BITS-1:0];
					CFG_SPIN_UP: spin_q  <= cfg_data[SPIN_BITS-1:0];
					default: ;
				endcase
			end
			if (acc) begin
				if (s_tlast) begin
					pix_q <= '0;
					if (div_now) frame_q <= frame_q + FRAME_BITS'(1);
				end else if ({1'b0, pix_q} >= LAST_ADDR) begin
					pix_q <= '0;
				end else begin
					pix_q <= pix_q + AW'(1);
				end
			end
		end
	end

	// Reciprocal sequencer: next state.
	always_comb begin
		div_state_next = div_state_q;
		case (div_state_q)
			DS_IDLE: if (frame_inc) div_state_next = DS_WAIT;
			DS_WAIT: if (pipe_empty) div_state_next = DS_RUN;
			DS_RUN:  if (cnt_q == '0) div_state_next = DS_IDLE;
			default: div_state_next = DS_IDLE;
		endcase
	end

	// Reciprocal sequencer: outputs.
	always_comb begin
		div_busy = 1'b1;
		div_run  = 1'b0;
		case (div_state_q)
			DS_IDLE: div_busy = 1'b0;
			DS_WAIT: div_busy = 1'b1;
			DS_RUN:  div_run  = 1'b1;
			default: div_busy = 1'b1;
		endcase
	end

	// One restoring step of floor(2^W / frame) per cycle.
	assign rem_shift = {rem_q[FRAME_BITS-1:0], (cnt_q == CW'(W))};
	assign rem_ge    = rem_shift >= {1'b0, frame_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_state_q <= DS_WAIT;
			cnt_q       <= '0;
		end else begin
			div_state_q <= div_state_next;
			if (div_state_q == DS_WAIT) cnt_q <= CW'(W);
			else if (div_run) cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (div_state_q == DS_WAIT) begin
			rem_q <= '0;
			quo_q <= '0;
		end else if (div_run) begin
			rem_q <= rem_ge ? rem_shift - {1'b0, frame_q} : rem_shift;
			quo_q <= {quo_q[RW-2:0], rem_ge};
			if (cnt_q == '0) recip_q <= {quo_q[RW-2:0], rem_ge};
		end
	end

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	// Frame store read at accept and write back from the last stage.
	always_ff @(posedge clk) begin
		if (acc) rd_s1 <= mem[pix_q];
		if (advance && v_s4) mem[addr_s4] <= res_s4;
	end

	// Stage 1: distance between the sample and the stored average.
	// The first frame starts from the sample itself, since its entries are not yet written.
	assign x_s1    = {smp_s1, {FRAC_BITS{1'b0}}};
	assign base_s1 = (f_s1 == FRAME_BITS'(1)) ? x_s1 : rd_s1;
	assign up_s1   = x_s1 >= base_s1;
	assign mag_s1  = up_s1 ? x_s1 - base_s1 : base_s1 - x_s1;

	// Stage 2: scale by the reciprocal or by alpha.
	assign op_s2 = div_s2 ? recip_q : {{(RW-ALPHA_BITS){1'b0}}, alpha_q};

	// Stage 3: quotient estimate and its back product.
	assign q_s3 = div_s3 ? prod_s3[2*W-1:W] : prod_s3[W+ALPHA_BITS-1:ALPHA_BITS];

	// Stage 4: quotient correction, update and rounding.
	assign diff_s4 = {{FRAME_BITS{1'b0}}, mag_s4} - qf_s4;
	assign corr_s4 = div_s4 && (diff_s4 >= {{W{1'b0}}, f_s4});
	assign step_s4 = q_s4 + W'(corr_s4);
	assign res_s4  = up_s4 ? avg_s4 + step_s4 : avg_s4 - step_s4;
	assign rnd_s4  = {1'b0, res_s4} + ((W+1)'(1) << (FRAC_BITS - 1));
	assign sh_s4   = rnd_s4[W:FRAC_BITS];
	assign filt_s4 = sh_s4[PIXEL_BITS] ? {PIXEL_BITS{1'b1}} : sh_s4[PIXEL_BITS-1:0];

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (advance) begin
			if (acc) begin
				addr_s1 <= pix_q;
				smp_s1  <= s_tdata[PIXEL_BITS-1:0];
				last_s1 <= s_tlast;
				div_s1  <= div_now;
				f_s1    <= frame_q;
			end
			addr_s2 <= addr_s1;
			last_s2 <= last_s1;
			div_s2  <= div_s1;
			f_s2    <= f_s1;
			up_s2   <= up_s1;
			avg_s2  <= base_s1;
			mag_s2  <= mag_s1;

			addr_s3 <= addr_s2;
			last_s3 <= last_s2;
			div_s3  <= div_s2;
			f_s3    <= f_s2;
			up_s3   <= up_s2;
			avg_s3  <= avg_s2;
			mag_s3  <= mag_s2;
			prod_s3 <= {{RW{1'b0}}, 1'b0, mag_s2} * {{RW{1'b0}}, op_s2};

			addr_s4 <= addr_s3;
			last_s4 <= last_s3;
			div_s4  <= div_s3;
			f_s4    <= f_s3;
			up_s4   <= up_s3;
			avg_s4  <= avg_s3;
			mag_s4  <= mag_s3;
			q_s4    <= q_s3;
			qf_s4   <= {{FRAME_BITS{1'b0}}, q_s3} * {{W{1'b0}}, f_s3};

			out_data_q <= filt_s4;
			out_last_q <= last_s4;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = DW'(out_data_q);
	assign m_tlast  = out_last_q;

	// No sample enters while the reciprocal is pending or being formed.
	a_no_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> div_state_q == DS_IDLE)
		else $error("sample accepted while reciprocal busy");

	// The reciprocal is formed only with an empty pipeline.
	a_run_empty: assert property (@(posedge clk) disable iff (!arst_n)
		div_run |-> pipe_empty)
		else $error("reciprocal formed with items in flight");

	// An accepted address never matches an update in stage 1 or stage 4.
	a_no_raw: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> !((v_s1 && addr_s1 == pix_q) || (v_s4 && addr_s4 == pix_q)))
		else $error("frame store read overlaps pending write");

	// After one correction the division remainder lies below the divisor.
	a_div_exact: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && div_s4) |-> (diff_s4 - (corr_s4 ? {{W{1'b0}}, f_s4} : '0))
			< {{W{1'b0}}, f_s4})
		else $error("quotient correction insufficient");

endmodule
